// ===== src/ahist_pkg.sv =====
`default_nettype none
package ahist_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int TYPE_W      = 5;
  localparam int TYPE_SLOTS  = 1 << TYPE_W;
  localparam int BYTE_W      = 8;
  localparam int RUN_W       = 2;
  localparam int FIFO_DEPTH  = 3;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [TYPE_W-1:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [BYTE_W-1:0] START_BYTE    = 8'h01;
  localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;
  localparam logic [RUN_W-1:0]  RUN_MAX       = 2'd3;
  localparam logic [RUN_W-1:0]  RUN_START_MIN = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [TYPE_W-1:0] nal_type;
  } ahist_hdr_t;

  typedef struct packed {
    logic              vld;
    logic [TYPE_W-1:0] nal_type;
    logic [OUT_W-1:0]  type_count;
    logic [OUT_W-1:0]  total_count;
  } ahist_res_t;

  function automatic logic [OUT_W-1:0] count_out(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, c};
    return ext[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/ahist_ram.sv =====
`default_nettype none
module ahist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ahist_scan.sv =====
`default_nettype none
module ahist_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic [ahist_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic                          packet_end,
  output ahist_pkg::ahist_hdr_t              hdr
);

  logic [ahist_pkg::RUN_W-1:0] zero_run_r, zero_run_nxt;
  logic                        hdr_pend_r, hdr_pend_nxt;

  always_comb begin
    zero_run_nxt = zero_run_r;
    hdr_pend_nxt = hdr_pend_r;
    hdr          = '0;
    if (in_fire) begin
      if (hdr_pend_r) begin
        hdr.vld      = 1'b1;
        hdr.nal_type = data_byte[ahist_pkg::TYPE_W-1:0] & ahist_pkg::NAL_TYPE_MASK;
        hdr_pend_nxt = 1'b0;
      end else if (data_byte == ahist_pkg::START_BYTE &&
                   zero_run_r >= ahist_pkg::RUN_START_MIN) begin
        hdr_pend_nxt = 1'b1;
      end
      if (data_byte == ahist_pkg::ZERO_BYTE) begin
        if (zero_run_r != ahist_pkg::RUN_MAX) begin
          zero_run_nxt = zero_run_r + 1'b1;
        end
      end else begin
        zero_run_nxt = '0;
      end
      if (packet_end) begin
        zero_run_nxt = '0;
        hdr_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= '0;
      hdr_pend_r <= 1'b0;
    end else begin
      zero_run_r <= zero_run_nxt;
      hdr_pend_r <= hdr_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ahist_count.sv =====
`default_nettype none
module ahist_count (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  ahist_pkg::ahist_hdr_t  hdr,
  output ahist_pkg::ahist_res_t  res
);

  localparam int CW = ahist_pkg::COUNT_WIDTH;
  localparam int TW = ahist_pkg::TYPE_W;

  logic                             s1_v_r, s1_v_nxt;
  logic [TW-1:0]                    s1_type_r, s1_type_nxt;
  logic                             fwd_v_r, fwd_v_nxt;
  logic [TW-1:0]                    fwd_type_r, fwd_type_nxt;
  logic [CW-1:0]                    fwd_data_r, fwd_data_nxt;
  logic [CW-1:0]                    total_r, total_nxt;
  logic [ahist_pkg::TYPE_SLOTS-1:0] seen_r, seen_nxt;

  logic [CW-1:0] rdata;
  logic [CW-1:0] base;
  logic [CW-1:0] new_cnt;
  logic [CW-1:0] new_total;

  ahist_ram #(
    .WIDTH(CW),
    .DEPTH(ahist_pkg::TYPE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (s1_v_r),
    .waddr(s1_type_r),
    .wdata(new_cnt),
    .re   (hdr.vld),
    .raddr(hdr.nal_type),
    .rdata(rdata)
  );

  // RAM returns old data on a same-cycle write; bypass the last write
  always_comb begin
    if (fwd_v_r && fwd_type_r == s1_type_r) begin
      base = fwd_data_r;
    end else if (seen_r[s1_type_r]) begin
      base = rdata;
    end else begin
      base = '0;
    end
    new_cnt   = base + CW'(1);
    new_total = total_r + CW'(1);

    s1_v_nxt     = hdr.vld;
    s1_type_nxt  = hdr.nal_type;
    fwd_v_nxt    = s1_v_r;
    fwd_type_nxt = s1_type_r;
    fwd_data_nxt = new_cnt;
    total_nxt    = total_r;
    seen_nxt     = seen_r;
    if (s1_v_r) begin
      total_nxt           = new_total;
      seen_nxt[s1_type_r] = 1'b1;
    end

    res.vld         = s1_v_r;
    res.nal_type    = s1_type_r;
    res.type_count  = ahist_pkg::count_out(new_cnt);
    res.total_count = ahist_pkg::count_out(new_total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      total_r <= '0;
      seen_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      fwd_v_r <= fwd_v_nxt;
      total_r <= total_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_type_r  <= s1_type_nxt;
    fwd_type_r <= fwd_type_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

endmodule
`default_nettype wire

// ===== src/ahist_fifo.sv =====
`default_nettype none
module ahist_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  ahist_pkg::ahist_res_t                res,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ahist_pkg::TYPE_W-1:0]         out_nal_type,
  output logic [ahist_pkg::OUT_W-1:0]          out_type_count,
  output logic [ahist_pkg::OUT_W-1:0]          out_total_count,
  output logic [ahist_pkg::FIFO_CW-1:0]        fill
);

  localparam int AW = ahist_pkg::FIFO_AW;
  localparam int CNTW = ahist_pkg::FIFO_CW;
  localparam logic [AW-1:0] LAST = AW'(ahist_pkg::FIFO_DEPTH - 1);

  ahist_pkg::ahist_res_t ent_r [ahist_pkg::FIFO_DEPTH];

  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  always_comb begin
    push       = res.vld;
    pop        = out_valid && out_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_nal_type    = ent_r[rd_ptr_r].nal_type;
  assign out_type_count  = ent_r[rd_ptr_r].type_count;
  assign out_total_count = ent_r[rd_ptr_r].total_count;
  assign fill            = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== src/annexb_nal_type_histogram_unit.sv =====
`default_nettype none
// Annex-B NAL type histogram. Scans one byte per clock (in_ready stays high
// while the output is drained); each NAL header byte found after a start code
// yields one registered transaction carrying the type, its updated count
// and the updated total. The 32 per-type counters sit in a one-port-write,
// one-port-read RAM updated read-modify-write with a one-entry bypass, so
// back-to-back headers of the same type need no stall. Per-entry valid flops
// make the counters read as zero after reset, so no clearing pass is needed.
// A three-entry output queue absorbs results while the output is stalled.
module annexb_nal_type_histogram_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ahist_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                              in_packet_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ahist_pkg::TYPE_W-1:0]           out_nal_type,
  output logic [ahist_pkg::OUT_W-1:0]            out_type_count,
  output logic [ahist_pkg::OUT_W-1:0]            out_total_count
);

  localparam int CNTW = ahist_pkg::FIFO_CW + 1;

  ahist_pkg::ahist_hdr_t               hdr;
  ahist_pkg::ahist_res_t               res;
  logic [ahist_pkg::FIFO_CW-1:0]       fill;
  logic                                in_fire;
  logic [CNTW-1:0]                     inflight;

  assign inflight = CNTW'(fill) + CNTW'(res.vld);
  assign in_ready = (inflight < CNTW'(ahist_pkg::FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;

  ahist_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .packet_end(in_packet_end),
    .hdr       (hdr)
  );

  ahist_count u_count (
    .clk  (clk),
    .rst_n(rst_n),
    .hdr  (hdr),
    .res  (res)
  );

  ahist_fifo u_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nal_type   (out_nal_type),
    .out_type_count (out_type_count),
    .out_total_count(out_total_count),
    .fill           (fill)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNTW'(fill) <= CNTW'(ahist_pkg::FIFO_DEPTH))
    else $error("output queue overfilled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && !(out_valid && out_ready)) |->
      (CNTW'(fill) < CNTW'(ahist_pkg::FIFO_DEPTH)))
    else $error("result pushed into full queue");

  a_hdr_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    hdr.vld |=> res.vld)
    else $error("header lost before counter update");

  a_hdr_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    hdr.vld |-> in_fire)
    else $error("header without accepted byte");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;

  typedef logic [ahist_pkg::BYTE_W-1:0] byte_t;
  typedef logic [ahist_pkg::OUT_W-1:0]  out_t;

  typedef struct packed {
    logic [ahist_pkg::TYPE_W-1:0] nal_type;
    logic [ahist_pkg::OUT_W-1:0]  type_count;
    logic [ahist_pkg::OUT_W-1:0]  total_count;
  } nal_rec_t;

  typedef struct packed {
    logic [ahist_pkg::BYTE_W-1:0] data_byte;
    logic                         packet_end;
    logic                         typed;
    nal_rec_t                     rec;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ahist_pkg::BYTE_W-1:0]  in_data_byte = '0;
  logic                          in_packet_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ahist_pkg::TYPE_W-1:0]  out_nal_type;
  logic [ahist_pkg::OUT_W-1:0]   out_type_count;
  logic [ahist_pkg::OUT_W-1:0]   out_total_count;

  annexb_nal_type_histogram_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_packet_end   (in_packet_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_nal_type    (out_nal_type),
    .out_type_count  (out_type_count),
    .out_total_count (out_total_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [ahist_pkg::RUN_W-1:0]       zrun;
  logic                              hdr_armed;
  logic [ahist_pkg::COUNT_WIDTH-1:0] type_tally [ahist_pkg::TYPE_SLOTS];
  logic [ahist_pkg::COUNT_WIDTH-1:0] units_seen;

  nal_rec_t  nal_expect_q [$];
  stim_row_t directed_q [$];
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        bytes_sent = 0;

  task automatic flag_mismatch(input string what, input logic [ahist_pkg::OUT_W-1:0] got,
                               input logic [ahist_pkg::OUT_W-1:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic bit scan_nal_byte(input logic [ahist_pkg::BYTE_W-1:0] b, input logic pe,
                                       output nal_rec_t rec);
    logic [ahist_pkg::TYPE_W-1:0] t;
    bit                           hit;
    hit = 1'b0;
    rec = '0;
    if (hdr_armed) begin
      t = b[ahist_pkg::TYPE_W-1:0] & ahist_pkg::NAL_TYPE_MASK;
      type_tally[t] = type_tally[t] + 1'b1;
      units_seen = units_seen + 1'b1;
      rec.nal_type = t;
      rec.type_count = type_tally[t];
      rec.total_count = units_seen;
      hit = 1'b1;
      hdr_armed = 1'b0;
    end else if (b == ahist_pkg::START_BYTE && zrun >= ahist_pkg::RUN_START_MIN) begin
      hdr_armed = 1'b1;
    end
    if (b == ahist_pkg::ZERO_BYTE) begin
      if (zrun < ahist_pkg::RUN_MAX) zrun = zrun + 1'b1;
    end else begin
      zrun = '0;
    end
    if (pe) begin
      zrun = '0;
      hdr_armed = 1'b0;
    end
    return hit;
  endfunction

  task automatic push_byte(input logic [ahist_pkg::BYTE_W-1:0] b, input logic pe,
                           input logic typed, input nal_rec_t typed_rec);
    nal_rec_t rec;
    bit       hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_packet_end <= pe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = scan_nal_byte(b, pe, rec);
    if (typed) nal_expect_q = {nal_expect_q, typed_rec};
    else if (hit) nal_expect_q = {nal_expect_q, rec};
    bytes_sent++;
  endtask

  function automatic void add_row(input logic [ahist_pkg::BYTE_W-1:0] b, input logic pe,
                                  input logic typed, input logic [ahist_pkg::TYPE_W-1:0] t,
                                  input logic [ahist_pkg::OUT_W-1:0] tc,
                                  input logic [ahist_pkg::OUT_W-1:0] tot);
    stim_row_t r;
    r.data_byte = b;
    r.packet_end = pe;
    r.typed = typed;
    r.rec.nal_type = t;
    r.rec.type_count = tc;
    r.rec.total_count = tot;
    directed_q = {directed_q, r};
  endfunction

  task automatic send_packet();
    byte_t pkt [$];
    int    n_units, nz, plen, roll, last;
    n_units = $urandom_range(1, 4);
    repeat (n_units) begin
      roll = $urandom_range(99);
      if (roll < 10) nz = $urandom_range(0, 1);
      else if (roll < 25) nz = $urandom_range(4, 7);
      else nz = $urandom_range(2, 3);
      repeat (nz) pkt = {pkt, ahist_pkg::ZERO_BYTE};
      pkt = {pkt, ahist_pkg::START_BYTE};
      if ($urandom_range(99) < 10) pkt = {pkt, ahist_pkg::ZERO_BYTE};
      else pkt = {pkt, byte_t'($urandom_range(255))};
      plen = $urandom_range(0, 8);
      repeat (plen) begin
        roll = $urandom_range(99);
        if (roll < 30) pkt = {pkt, ahist_pkg::ZERO_BYTE};
        else if (roll < 40) pkt = {pkt, ahist_pkg::START_BYTE};
        else pkt = {pkt, byte_t'($urandom_range(255))};
      end
    end
    last = pkt.size() - 1;
    if ($urandom_range(99) < 20) last = $urandom_range(0, pkt.size() - 1);
    for (int i = 0; i <= last; i++) push_byte(pkt[i], i == last, 1'b0, '0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) push_byte(byte_t'($urandom_range(255)), $urandom_range(1) != 0, 1'b0, '0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_bytes);
    int stop_at;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_packet();
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    nal_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (nal_expect_q.size() == 0) begin
        flag_mismatch("unexpected transaction", out_total_count, '0);
      end else begin
        want = nal_expect_q.pop_front();
        if (out_nal_type !== want.nal_type)
          flag_mismatch("nal_type", out_t'(out_nal_type), out_t'(want.nal_type));
        if (out_type_count !== want.type_count)
          flag_mismatch("type_count", out_type_count, want.type_count);
        if (out_total_count !== want.total_count)
          flag_mismatch("total_count", out_total_count, want.total_count);
      end
    end
  end

  initial begin
    zrun = '0;
    hdr_armed = 1'b0;
    units_seen = '0;
    for (int k = 0; k < ahist_pkg::TYPE_SLOTS; k++) type_tally[k] = '0;

    // three-byte start code
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h09, 1'b0, 1'b1, 5'd9, 32'd1, 32'd1);
    // four-byte start code
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h67, 1'b0, 1'b1, 5'd7, 32'd1, 32'd2);
    // saturated zero run, header is last byte of packet
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'hff, 1'b1, 1'b1, 5'd31, 32'd1, 32'd3);
    // start code closes the packet: nothing counted
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b1, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h05, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    // zero header byte opens the next start code
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h00, 1'b0, 1'b1, 5'd0, 32'd1, 32'd4);
    add_row(8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h01, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0);
    add_row(8'h80, 1'b1, 1'b0, 5'd0, 32'd0, 32'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i])
      push_byte(directed_q[i].data_byte, directed_q[i].packet_end, directed_q[i].typed,
                directed_q[i].rec);

    run_phase(0, 0, 410);
    run_phase(63, 0, 410);
    run_phase(0, 63, 410);
    run_phase(26, 26, 410);
    in_valid <= 1'b0;

    while (nal_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (nal_expect_q.size() != 0)
      flag_mismatch("transactions never delivered", out_t'(nal_expect_q.size()), '0);
    if (err_count == 0) begin
      $display("[annexb_nal_type_histogram_unit] OK");
    end else begin
      $display("[annexb_nal_type_histogram_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[annexb_nal_type_histogram_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ahist_pkg.sv
src/ahist_ram.sv
src/ahist_scan.sv
src/ahist_count.sv
src/ahist_fifo.sv
src/annexb_nal_type_histogram_unit.sv
bench/tb.sv
